@@ design/scfp_pkg.sv @@
// Shared types, character codes and keyword tables of the serial command frame parser.
package scfp_pkg;

    localparam int NAME_LEN_DEF   = 4;
    localparam int VALUE_ROOM_DEF = 16;

    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_TAB   = 8'h09;

    localparam int NUM_CMDS = 5;

    localparam logic [2:0] CMD_CPU_TEMP  = 3'd0;
    localparam logic [2:0] CMD_GPU_TEMP  = 3'd1;
    localparam logic [2:0] CMD_CPU_LOAD  = 3'd2;
    localparam logic [2:0] CMD_GPU_LOAD  = 3'd3;
    localparam logic [2:0] CMD_UNIX_TIME = 3'd4;

    // Command names in command id order.
    localparam logic [7:0] KNOWN_NAMES [NUM_CMDS][4] = '{
        '{8'h63, 8'h70, 8'h75, 8'h74},  // cput
        '{8'h67, 8'h70, 8'h75, 8'h74},  // gput
        '{8'h63, 8'h70, 8'h75, 8'h6C},  // cpul
        '{8'h67, 8'h70, 8'h75, 8'h6C},  // gpul
        '{8'h75, 8'h6E, 8'h69, 8'h78}   // unix
    };

    localparam logic [7:0] WORD_TRUE  [4] = '{8'h74, 8'h72, 8'h75, 8'h65};
    localparam logic [7:0] WORD_FALSE [5] = '{8'h66, 8'h61, 8'h6C, 8'h73, 8'h65};

    localparam logic [2:0] TRUE_DONE  = 3'd4;
    localparam logic [2:0] FALSE_DONE = 3'd5;
    localparam logic [2:0] PROG_FAIL  = 3'd7;

    localparam logic [35:0] POS_LIMIT = 36'h0_7FFF_FFFF;
    localparam logic [35:0] NEG_LIMIT = 36'h0_8000_0000;

    typedef enum logic [1:0] {
        PH_SKIP_WS = 2'd0,
        PH_SIGNED  = 2'd1,
        PH_DIGITS  = 2'd2,
        PH_DONE    = 2'd3
    } t_num_phase;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       menu_active;
    } t_in_item;

    typedef struct packed {
        logic [2:0]         cmd_id;
        logic signed [31:0] cmd_value;
    } t_out_item;

    typedef struct packed {
        logic [31:0] acc;
        logic        negative;
        logic [2:0]  true_prog;
        logic [2:0]  false_prog;
    } t_value_state;

endpackage

@@ design/scfp_value_parser.sv @@
// Running parse of the value text: true/false keyword match and saturating decimal value.
module scfp_value_parser
    import scfp_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_clear,
    input  logic         i_step,
    input  logic [7:0]   i_byte,
    output t_value_state o_state
);

    t_num_phase   r_phase, n_phase;
    t_value_state r_val, n_val;

    logic [35:0] w_next;
    logic [35:0] w_limit;
    logic        w_digit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SKIP_WS;
            r_val   <= '0;
        end else begin
            r_phase <= n_phase;
            r_val   <= n_val;
        end
    end

    assign w_digit = (i_byte >= CH_ZERO) && (i_byte <= CH_NINE);
    assign w_limit = r_val.negative ? NEG_LIMIT : POS_LIMIT;
    // acc * 10 as (acc << 3) + (acc << 1), plus the digit.
    assign w_next  = {1'b0, r_val.acc, 3'b000} + {3'b000, r_val.acc, 1'b0}
                   + {32'd0, i_byte[3:0] - CH_ZERO[3:0]};

    always_comb begin
        n_phase = r_phase;
        n_val   = r_val;
        if (i_clear) begin
            n_phase = PH_SKIP_WS;
            n_val   = '0;
        end else if (i_step) begin
            if (r_val.true_prog < TRUE_DONE) begin
                n_val.true_prog = (i_byte == WORD_TRUE[r_val.true_prog[1:0]])
                                ? r_val.true_prog + 3'd1 : PROG_FAIL;
            end
            if (r_val.false_prog < FALSE_DONE) begin
                n_val.false_prog = (i_byte == WORD_FALSE[r_val.false_prog])
                                 ? r_val.false_prog + 3'd1 : PROG_FAIL;
            end
            if (r_phase != PH_DONE) begin
                if (w_digit) begin
                    n_val.acc = (w_next > w_limit) ? w_limit[31:0] : w_next[31:0];
                    n_phase   = PH_DIGITS;
                end else if (r_phase == PH_SKIP_WS &&
                             (i_byte == CH_SPACE || i_byte inside {[CH_TAB:CH_CR]})) begin
                    n_phase = PH_SKIP_WS;
                end else if (r_phase == PH_SKIP_WS &&
                             (i_byte == CH_PLUS || i_byte == CH_MINUS)) begin
                    n_val.negative = (i_byte == CH_MINUS);
                    n_phase        = PH_SIGNED;
                end else begin
                    n_phase = PH_DONE;
                end
            end
        end
    end

    assign o_state = r_val;

endmodule

@@ design/serial_command_frame_parser.sv @@
// Top level of the serial command frame parser: frame tracking, name match and result register.
//
//   channel | direction | handshake                | payload
//   --------+-----------+--------------------------+-----------------------------
//   in      | input     | i_in_valid / o_in_ready  | i_in_data  (t_in_item)
//   out     | output    | o_out_valid / i_out_ready| o_out_data (t_out_item)
//
// A byte is taken into the input register; when the output register is free or its
// result is taken, the byte's frame update is applied and any result is loaded into the
// output register: one byte per cycle while results are taken, set by the single update path.
// Reset (synchronous, active low) empties both registers and starts an empty frame.
// A result waiting in the output register stalls the input register whenever a byte
// is waiting behind it and the result is not taken in that cycle.
module serial_command_frame_parser
    import scfp_pkg::*;
#(
    parameter int NAME_LEN   = NAME_LEN_DEF,
    parameter int VALUE_ROOM = VALUE_ROOM_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    localparam int FRAME_CAP = NAME_LEN + VALUE_ROOM - 1;
    localparam int CNT_W     = $clog2(FRAME_CAP + 1);
    localparam logic [CNT_W-1:0] CAP_C  = CNT_W'(FRAME_CAP);
    localparam logic [CNT_W-1:0] NAME_C = CNT_W'(NAME_LEN);

    logic      r_in_valid;
    t_in_item  r_in;
    logic      r_out_valid;
    t_out_item r_out;

    logic [CNT_W-1:0]         r_cnt, n_cnt;
    logic [NAME_LEN-1:0][7:0] r_name, n_name;
    logic                     r_colon, n_colon;

    logic         w_go;
    logic         w_semi, w_crlf, w_full, w_store;
    logic         w_clear, w_step;
    logic         w_hit;
    logic [31:0]  w_val;
    logic [2:0]   w_id;
    logic         w_any;
    t_value_state w_vs;

    // Name compare: positions beyond the four keyword characters hold a terminator.
    function automatic logic name_hit(input logic [NAME_LEN-1:0][7:0] nm,
                                      input logic [2:0] k);
        logic       ok;
        logic       stop;
        logic [7:0] want;
        ok   = 1'b1;
        stop = 1'b0;
        for (int i = 0; i < NAME_LEN; i++) begin
            want = (i < 4) ? KNOWN_NAMES[k][i[1:0]] : 8'h00;
            if (!stop) begin
                if (nm[i] != want) ok = 1'b0;
                if (want == 8'h00) stop = 1'b1;
            end
        end
        return ok;
    endfunction

    assign w_go       = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    assign w_semi  = (r_in.rx_byte == CH_SEMI);
    assign w_crlf  = (r_in.rx_byte == CH_CR) || (r_in.rx_byte == CH_LF);
    assign w_full  = (r_cnt >= CAP_C);
    assign w_store = w_go && !w_semi && !w_crlf && !w_full;
    assign w_clear = w_go && (w_semi || (!w_crlf && w_full));
    assign w_step  = w_store && (r_cnt > NAME_C);

    scfp_value_parser u_value (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (w_clear),
        .i_step  (w_step),
        .i_byte  (r_in.rx_byte),
        .o_state (w_vs)
    );

    always_comb begin
        n_cnt   = r_cnt;
        n_name  = r_name;
        n_colon = r_colon;
        if (w_clear) begin
            n_cnt   = '0;
            n_name  = '0;
            n_colon = 1'b0;
        end else if (w_store) begin
            n_cnt = r_cnt + CNT_W'(1);
            for (int i = 0; i < NAME_LEN; i++) begin
                if (r_cnt == CNT_W'(i)) n_name[i] = r_in.rx_byte;
            end
            if (r_cnt == NAME_C) n_colon = (r_in.rx_byte == CH_COLON);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_name  <= '0;
            r_colon <= 1'b0;
        end else begin
            r_cnt   <= n_cnt;
            r_name  <= n_name;
            r_colon <= n_colon;
        end
    end

    always_comb begin
        if (w_vs.true_prog == TRUE_DONE) begin
            w_val = 32'd1;
        end else if (w_vs.false_prog == FALSE_DONE) begin
            w_val = 32'd0;
        end else if (w_vs.negative) begin
            w_val = 32'd0 - w_vs.acc;
        end else begin
            w_val = w_vs.acc;
        end
    end

    // The first matching name in command order wins.
    always_comb begin
        w_id  = CMD_CPU_TEMP;
        w_any = 1'b0;
        for (int k = NUM_CMDS - 1; k >= 0; k--) begin
            if (name_hit(r_name, 3'(k))) begin
                w_id  = 3'(k);
                w_any = 1'b1;
            end
        end
    end

    // A value of minus one is treated as no command.
    assign w_hit = w_semi && !r_in.menu_active && r_colon && (r_cnt > NAME_C)
                 && (w_val != 32'hFFFF_FFFF) && w_any;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_go && w_hit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_go && w_hit) begin
            r_out.cmd_id    <= w_id;
            r_out.cmd_value <= w_val;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

@@ design/scfp_checker.sv @@
// Port-level checks of the serial command frame parser, bound to its top level.
module scfp_checker
    import scfp_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_in_ready,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out_data
);

    // A result that is not taken stays, unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result dropped or changed while stalled");

    a_id_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.cmd_id <= CMD_UNIX_TIME))
        else $error("command id out of range");

    a_no_minus_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.cmd_value != -32'sd1))
        else $error("value of minus one was emitted");

    // The first cycle after reset shows neither a result nor a stalled input.
    a_reset_idle: assert property (@(posedge i_clk)
        i_rst_n && !$past(i_rst_n) |-> !o_out_valid && o_in_ready)
        else $error("block not idle after reset");

endmodule

bind serial_command_frame_parser scfp_checker u_scfp_checker (.*);
